// ===== src/lru_fifo_replacement_table_macros.svh =====
// Assertion macros for the replacement table checker.
// Both sample on the rising edge of i_clk; the first is gated by reset.
`ifndef LRU_FIFO_REPLACEMENT_TABLE_MACROS_SVH
`define LRU_FIFO_REPLACEMENT_TABLE_MACROS_SVH

// checked outside reset only
`define LFT_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("lft_checker: property violated");

// checked on every edge, reset included
`define LFT_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("lft_checker: property violated");

`endif

// ===== src/lft_pkg.sv =====
// Shared types and constants for the replacement table.
// No dependencies.
package lft_pkg;

    localparam int ENTRIES_DEF  = 16;
    localparam int KEY_BITS_DEF = 64;

    localparam logic        LRU_MODE_RESET  = 1'b1;
    localparam logic [4:0]  CAPACITY_RESET  = 5'd16;
    localparam logic [20:0] MAX_BYTES_RESET = 21'd1048576;

    localparam logic REQ_LOOKUP = 1'b0;
    localparam logic REQ_INSERT = 1'b1;

    localparam logic [1:0] CFG_LRU_MODE  = 2'd0;
    localparam logic [1:0] CFG_CAPACITY  = 2'd1;
    localparam logic [1:0] CFG_MAX_BYTES = 2'd2;

    typedef enum logic [2:0] {
        ST_MISS      = 3'd0,
        ST_HIT       = 3'd1,
        ST_STORED    = 3'd2,
        ST_TOO_LARGE = 3'd3,
        ST_OFF       = 3'd4,
        ST_PRESENT   = 3'd5
    } t_status;

    typedef struct packed {
        logic        req_type;
        logic [63:0] key_tag;
        logic [23:0] body_bytes;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic [3:0]  slot;
        logic        evicted;
        logic [63:0] evicted_key;
    } t_res;

    typedef struct packed {
        logic        lru_mode;
        logic [4:0]  capacity;
        logic [20:0] max_bytes;
    } t_cfg;

endpackage

// ===== src/lru_fifo_replacement_table.sv =====
// A request is searched in one pass over the entry memory; a second pass rewrites
// ranks only when ranks change (LRU hit, store), not on a miss, a refusal or a FIFO hit.
// The next request is taken only once the previous result has entered the output register:
// the entry memory is swept one slot per cycle to search, and again to age.
// Reset (sync, active low): valid bits and entry count cleared, config registers
// to defaults, output emptied; memory contents left as is, gated by valid bits.
module lru_fifo_replacement_table #(
    parameter int ENTRIES  = lft_pkg::ENTRIES_DEF,
    parameter int KEY_BITS = lft_pkg::KEY_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_stall,
    input  lft_pkg::t_req i_req,
    output logic          o_res_valid,
    input  logic          i_res_stall,
    output lft_pkg::t_res o_res,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [1:0]    i_cfg_index,
    input  logic [20:0]   i_cfg_data
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int ENT_W = IDX_W + KEY_BITS;

    logic          r_lru_mode;
    logic [4:0]    r_capacity;
    logic [20:0]   r_max_bytes;
    logic          r_out_valid;
    lft_pkg::t_res r_out;

    lft_pkg::t_cfg    cfg;
    lft_pkg::t_res    ctrl_res;
    logic             ctrl_done;
    logic             res_take;
    logic [IDX_W-1:0] rd_addr;
    logic [ENT_W-1:0] rd_data;
    logic             we;
    logic [IDX_W-1:0] wr_addr;
    logic [ENT_W-1:0] wr_data;

    assign o_cfg_ready   = 1'b1;
    assign cfg.lru_mode  = r_lru_mode;
    assign cfg.capacity  = r_capacity;
    assign cfg.max_bytes = r_max_bytes;

    // output register frees when empty or being drained this cycle
    assign res_take    = !r_out_valid || !i_res_stall;
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lru_mode  <= lft_pkg::LRU_MODE_RESET;
            r_capacity  <= lft_pkg::CAPACITY_RESET;
            r_max_bytes <= lft_pkg::MAX_BYTES_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                lft_pkg::CFG_LRU_MODE:  r_lru_mode  <= i_cfg_data[0];
                lft_pkg::CFG_CAPACITY:  r_capacity  <= i_cfg_data[4:0];
                lft_pkg::CFG_MAX_BYTES: r_max_bytes <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl_done && res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_res_stall) begin
            r_out_valid <= 1'b0;
        end
        if (ctrl_done && res_take) begin
            r_out <= ctrl_res;
        end
    end

    lft_ctrl #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS),
        .IDX_W    (IDX_W),
        .ENT_W    (ENT_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .i_req       (i_req),
        .i_cfg       (cfg),
        .o_done      (ctrl_done),
        .o_res       (ctrl_res),
        .i_res_take  (res_take),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_we        (we),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data)
    );

    lft_mem #(
        .DEPTH (ENTRIES),
        .WIDTH (ENT_W),
        .AW    (IDX_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_we      (we),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

endmodule

// ===== src/lft_mem.sv =====
// Entry memory: one write port, one read port with registered data.
// Holds rank and key per slot. No package dependency.
module lft_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 68,
    parameter int AW    = 4
) (
    input  logic             i_clk,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data,
    input  logic             i_we,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/lft_ctrl.sv =====
// Sequencer: scans the entry memory for match, oldest and free slot, decides the
// outcome, then for an LRU hit or a store rewrites ranks in a second pass. Uses lft_pkg.
module lft_ctrl #(
    parameter int ENTRIES  = lft_pkg::ENTRIES_DEF,
    parameter int KEY_BITS = lft_pkg::KEY_BITS_DEF,
    parameter int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
    parameter int ENT_W    = IDX_W + KEY_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_stall,
    input  lft_pkg::t_req     i_req,
    input  lft_pkg::t_cfg     i_cfg,
    output logic              o_done,
    output lft_pkg::t_res     o_res,
    input  logic              i_res_take,
    output logic [IDX_W-1:0]  o_rd_addr,
    input  logic [ENT_W-1:0]  i_rd_data,
    output logic              o_we,
    output logic [IDX_W-1:0]  o_wr_addr,
    output logic [ENT_W-1:0]  o_wr_data
);

    localparam int PTR_W = IDX_W + 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;
    localparam logic [PTR_W-1:0] PTR_END = PTR_W'(ENTRIES);
    localparam logic [CMP_W-1:0] ENT_CMP = CMP_W'(ENTRIES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_UPD,
        S_DONE
    } t_state;

    t_state               r_state, n_state;
    logic [PTR_W-1:0]     r_ptr, n_ptr;
    logic [ENTRIES-1:0]   r_valid, n_valid;
    logic [CNT_W-1:0]     r_count, n_count;
    logic                 r_type, n_type;
    logic [KEY_BITS-1:0]  r_key, n_key;
    logic [23:0]          r_bytes, n_bytes;
    logic                 r_hit_f, n_hit_f;
    logic [IDX_W-1:0]     r_hit_idx, n_hit_idx;
    logic [IDX_W-1:0]     r_hit_rank, n_hit_rank;
    logic                 r_old_f, n_old_f;
    logic [IDX_W-1:0]     r_old_idx, n_old_idx;
    logic [IDX_W-1:0]     r_old_rank, n_old_rank;
    logic [KEY_BITS-1:0]  r_old_key, n_old_key;
    logic                 r_free_f, n_free_f;
    logic [IDX_W-1:0]     r_free_idx, n_free_idx;
    logic                 r_upd_ins, n_upd_ins;
    logic [IDX_W-1:0]     r_tgt, n_tgt;
    logic [IDX_W-1:0]     r_ref_rank, n_ref_rank;
    lft_pkg::t_res        r_res, n_res;

    logic [PTR_W-1:0]     ptr_m1;
    logic [IDX_W-1:0]     j;
    logic                 proc;
    logic [IDX_W-1:0]     rd_rank;
    logic [KEY_BITS-1:0]  rd_key;
    logic [CMP_W-1:0]     cap_x;
    logic [CMP_W-1:0]     cap_eff;
    logic                 cap_zero;
    logic                 full;
    logic                 evict;
    logic                 have_slot;
    logic [IDX_W-1:0]     sel;
    logic [IDX_W+3:0]     slot_wide;
    logic [IDX_W-1:0]     new_rank;
    logic [KEY_BITS-1:0]  new_key;

    assign o_req_stall = (r_state != S_IDLE);
    assign o_done      = (r_state == S_DONE);
    assign o_res       = r_res;

    assign ptr_m1  = r_ptr - PTR_W'(1);
    assign j       = ptr_m1[IDX_W-1:0];
    assign proc    = (r_ptr != '0);
    assign rd_rank = i_rd_data[ENT_W-1:KEY_BITS];
    assign rd_key  = i_rd_data[KEY_BITS-1:0];

    // read k while writing back k-1: the two never meet, no forwarding needed
    assign o_rd_addr = (r_ptr < PTR_END) ? r_ptr[IDX_W-1:0] : '0;

    assign cap_x    = CMP_W'(i_cfg.capacity);
    assign cap_eff  = (cap_x > ENT_CMP) ? ENT_CMP : cap_x;
    assign cap_zero = (i_cfg.capacity == '0);
    assign full     = (CMP_W'(r_count) >= cap_eff);
    assign evict    = full && r_old_f;

    always_comb begin
        if (evict) begin
            have_slot = 1'b1;
            sel = (r_free_f && (r_free_idx < r_old_idx)) ? r_free_idx : r_old_idx;
        end else begin
            have_slot = r_free_f;
            sel = r_free_idx;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_ptr      = r_ptr;
        n_valid    = r_valid;
        n_count    = r_count;
        n_type     = r_type;
        n_key      = r_key;
        n_bytes    = r_bytes;
        n_hit_f    = r_hit_f;
        n_hit_idx  = r_hit_idx;
        n_hit_rank = r_hit_rank;
        n_old_f    = r_old_f;
        n_old_idx  = r_old_idx;
        n_old_rank = r_old_rank;
        n_old_key  = r_old_key;
        n_free_f   = r_free_f;
        n_free_idx = r_free_idx;
        n_upd_ins  = r_upd_ins;
        n_tgt      = r_tgt;
        n_ref_rank = r_ref_rank;
        n_res      = r_res;
        slot_wide  = '0;
        new_rank   = '0;
        new_key    = rd_key;
        o_we       = 1'b0;
        o_wr_addr  = j;
        o_wr_data  = i_rd_data;

        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_type   = i_req.req_type;
                    n_key    = i_req.key_tag[KEY_BITS-1:0];
                    n_bytes  = i_req.body_bytes;
                    n_hit_f  = 1'b0;
                    n_old_f  = 1'b0;
                    n_free_f = 1'b0;
                    n_ptr    = '0;
                    n_state  = S_SCAN;
                end
            end
            S_SCAN: begin
                if (proc) begin
                    if (r_valid[j] && (rd_key == r_key) && !r_hit_f) begin
                        n_hit_f    = 1'b1;
                        n_hit_idx  = j;
                        n_hit_rank = rd_rank;
                    end
                    if (r_valid[j] && (!r_old_f || (rd_rank > r_old_rank))) begin
                        n_old_f    = 1'b1;
                        n_old_idx  = j;
                        n_old_rank = rd_rank;
                        n_old_key  = rd_key;
                    end
                    if (!r_valid[j] && !r_free_f) begin
                        n_free_f   = 1'b1;
                        n_free_idx = j;
                    end
                end
                if (r_ptr == PTR_END) begin
                    n_state = S_DECIDE;
                end else begin
                    n_ptr = r_ptr + PTR_W'(1);
                end
            end
            S_DECIDE: begin
                n_res.status      = lft_pkg::ST_MISS;
                n_res.slot        = '0;
                n_res.evicted     = 1'b0;
                n_res.evicted_key = '0;
                n_state           = S_DONE;
                n_ptr             = '0;
                if (r_type == lft_pkg::REQ_LOOKUP) begin
                    if (!cap_zero && r_hit_f) begin
                        slot_wide    = {4'b0, r_hit_idx};
                        n_res.status = lft_pkg::ST_HIT;
                        n_res.slot   = slot_wide[3:0];
                        if (i_cfg.lru_mode) begin
                            n_upd_ins  = 1'b0;
                            n_tgt      = r_hit_idx;
                            n_ref_rank = r_hit_rank;
                            n_state    = S_UPD;
                        end
                    end
                end else if (cap_zero) begin
                    n_res.status = lft_pkg::ST_OFF;
                end else if ({3'b0, i_cfg.max_bytes} <= r_bytes) begin
                    n_res.status = lft_pkg::ST_TOO_LARGE;
                end else if (r_hit_f) begin
                    slot_wide    = {4'b0, r_hit_idx};
                    n_res.status = lft_pkg::ST_PRESENT;
                    n_res.slot   = slot_wide[3:0];
                end else begin
                    if (evict) begin
                        n_valid[r_old_idx] = 1'b0;
                        n_res.evicted      = 1'b1;
                        n_res.evicted_key  = 64'(r_old_key);
                    end
                    if (have_slot) begin
                        slot_wide    = {4'b0, sel};
                        n_valid[sel] = 1'b1;
                        n_res.status = lft_pkg::ST_STORED;
                        n_res.slot   = slot_wide[3:0];
                        n_upd_ins    = 1'b1;
                        n_tgt        = sel;
                        n_state      = S_UPD;
                    end
                    n_count = r_count + CNT_W'(have_slot) - CNT_W'(evict);
                end
            end
            S_UPD: begin
                // valid bits already reflect the eviction and the new slot
                if (j == r_tgt) begin
                    new_rank = '0;
                    new_key  = r_upd_ins ? r_key : rd_key;
                end else if (r_valid[j] && (r_upd_ins || (rd_rank < r_ref_rank))) begin
                    new_rank = rd_rank + IDX_W'(1);
                end else begin
                    new_rank = rd_rank;
                end
                o_we      = proc;
                o_wr_data = {new_rank, new_key};
                if (r_ptr == PTR_END) begin
                    n_state = S_DONE;
                end else begin
                    n_ptr = r_ptr + PTR_W'(1);
                end
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_count <= n_count;
        end
        r_ptr      <= n_ptr;
        r_type     <= n_type;
        r_key      <= n_key;
        r_bytes    <= n_bytes;
        r_hit_f    <= n_hit_f;
        r_hit_idx  <= n_hit_idx;
        r_hit_rank <= n_hit_rank;
        r_old_f    <= n_old_f;
        r_old_idx  <= n_old_idx;
        r_old_rank <= n_old_rank;
        r_old_key  <= n_old_key;
        r_free_f   <= n_free_f;
        r_free_idx <= n_free_idx;
        r_upd_ins  <= n_upd_ins;
        r_tgt      <= n_tgt;
        r_ref_rank <= n_ref_rank;
        r_res      <= n_res;
    end

endmodule

// ===== src/lft_checker.sv =====
// Port-level checks for the replacement table, bound to the top level.
// Uses lft_pkg and the assertion macros header.
`include "lru_fifo_replacement_table_macros.svh"

module lft_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_req_valid,
    input logic          o_req_stall,
    input logic          o_res_valid,
    input logic          i_res_stall,
    input lft_pkg::t_res o_res
);

    logic ev_seen;
    logic ev_store;
    logic res_refused;

    assign ev_seen     = o_res.evicted || (o_res.evicted_key != '0);
    assign ev_store    = (o_res.status == lft_pkg::ST_STORED) && o_res.evicted;
    assign res_refused = (o_res.status == lft_pkg::ST_MISS)
                      || (o_res.status == lft_pkg::ST_TOO_LARGE)
                      || (o_res.status == lft_pkg::ST_OFF);

    `LFT_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_res_valid)

    `LFT_ASSERT(a_busy_after_accept, i_req_valid && !o_req_stall |=> o_req_stall)

    `LFT_ASSERT(a_res_hold, o_res_valid && i_res_stall |=> o_res_valid && $stable(o_res))

    `LFT_ASSERT(a_evict_only_store, o_res_valid && ev_seen |-> ev_store)

    `LFT_ASSERT(a_no_slot_refusal, o_res_valid && res_refused |-> o_res.slot == '0)

endmodule

bind lru_fifo_replacement_table lft_checker u_chk (.*);
